/* rtl/jprt_pkg.sv */
// Shared constants and helpers for the Jacobi rotation tangent block.
package jprt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SUM_W      = 64;
  // shared multiplier operand width: doubled gradient magnitude or a closing value
  localparam int MUL_W      = (DATA_WIDTH + 1 > 33) ? DATA_WIDTH + 1 : 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int NORM_BIT   = 29;
  localparam int FRAC_BITS  = 30;
  localparam int DEN_W      = 34;
  localparam int RES_W      = 32;

  localparam logic signed [SUM_W-1:0] SUM_LIM = {1'b0, {(SUM_W-1){1'b1}}};

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // clamp a product magnitude to SUM_LIM
  function automatic logic [SUM_W-1:0] clamp_prod(input logic [PROD_W-1:0] p);
    logic [SUM_W-1:0] r;
    r = (|p[PROD_W-1:SUM_W-1]) ? SUM_LIM : p[SUM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                                      input logic [SUM_W-1:0] mag,
                                                      input logic neg);
    logic signed [SUM_W+1:0] a;
    logic signed [SUM_W+1:0] m;
    logic signed [SUM_W+1:0] s;
    logic signed [SUM_W-1:0] r;
    a = {{2{acc[SUM_W-1]}}, acc};
    m = $signed({2'b00, mag});
    s = neg ? (a - m) : (a + m);
    if (s >= $signed({2'b00, SUM_LIM})) begin
      r = SUM_LIM;
    end else if (s <= -$signed({2'b00, SUM_LIM})) begin
      r = -SUM_LIM;
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/jprt_div.sv */
// Restoring divider, one quotient bit per cycle.
module jprt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jprt_pkg::SUM_W-1:0]    num,
  input  logic [jprt_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [jprt_pkg::RES_W-1:0]    quot
);

  logic                         busy_r;
  logic                         done_r;
  logic [5:0]                   cnt_r;
  logic [jprt_pkg::SUM_W-1:0]   num_r;
  logic [jprt_pkg::DEN_W-1:0]   rem_r;
  logic [jprt_pkg::DEN_W-1:0]   den_r;
  logic [jprt_pkg::DEN_W:0]     trial;
  logic [jprt_pkg::DEN_W:0]     diff;
  logic                         fits;

  assign trial = {rem_r, num_r[jprt_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? diff[jprt_pkg::DEN_W-1:0]
                      : trial[jprt_pkg::DEN_W-1:0];
        num_r <= {num_r[jprt_pkg::SUM_W-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = num_r[jprt_pkg::RES_W-1:0];

endmodule

/* rtl/jacobi_pair_rotation_tangent_top.sv */
// Jacobi pair rotation tangent: sum accumulation and closing -tan(theta) sequencer.
// Each (b, g) word goes through states ST_MB, ST_AB, ST_AG, ST_AC before the next word
// can be taken; the three products go through one shared registered multiplier and one
// saturating adder. A word flagged last_state then clears the sums and runs the closing
// sequence on the same multiplier, a normalizing shift, a bit-serial square root (32
// steps, run twice) and a bit-serial divider (64 steps, skipped when the quotient is
// zero), before the result word is offered. in_stall is high for the whole time a
// word is in work.
module jacobi_pair_rotation_tangent_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_b_term,
  input  logic signed [31:0]                  in_g_term,
  input  logic                                in_last_state,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jprt_pkg::RES_W-1:0]   out_neg_tan_theta
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MB, ST_AB, ST_AG, ST_AC, ST_CLOSE, ST_SHIFT, ST_SQX, ST_SQY,
    ST_SQSUM, ST_ADD, ST_ROOT, ST_HALF, ST_DIVS, ST_DIVW, ST_DONE
  } state_t;

  localparam int MW = jprt_pkg::MUL_W;
  localparam int SW = jprt_pkg::SUM_W;
  localparam int DW = jprt_pkg::DATA_WIDTH;

  state_t                        state_r;
  logic [MW-1:0]                 a_r, b_r;
  logic [jprt_pkg::PROD_W-1:0]   p_r;
  logic [DW-1:0]                 mb_r;
  logic [DW:0]                   mg_r;
  logic                          xsign_r, last_r;
  logic signed [SW-1:0]          sum_b_r, sum_g_r, sum_c_r;
  logic [SW-1:0]                 xm_r, ym_r;
  logic                          xneg_r, yneg_r, yzero_r, qneg_r, phase_r;
  logic [MW-1:0]                 u_r, w_r;
  logic [SW-1:0]                 v_r, res_r, bit_r;
  logic [jprt_pkg::DEN_W-1:0]    den_r;
  logic [jprt_pkg::RES_W-1:0]    result_r;
  logic                          out_valid_r;
  logic [jprt_pkg::RES_W-1:0]    out_data_r;
  logic                          div_start;
  logic                          div_done;
  logic [jprt_pkg::RES_W-1:0]    div_quot;
  logic [SW-1:0]                 div_num;

  logic signed [SW-1:0]          xon, ac;
  logic [SW-1:0]                 trial;
  logic [DW-1:0]                 mag_b, mag_g;

  assign mag_b   = jprt_pkg::mag_of(in_b_term[DW-1:0]);
  assign mag_g   = jprt_pkg::mag_of(in_g_term[DW-1:0]);
  assign xon     = sum_b_r - sum_g_r;
  assign ac      = sum_c_r[SW-1] ? -sum_c_r : sum_c_r;
  assign trial   = res_r + bit_r;
  assign div_num = ({{(SW-MW){1'b0}}, w_r} << jprt_pkg::FRAC_BITS)
                 + {{(SW-jprt_pkg::DEN_W){1'b0}}, den_r >> 1};
  assign div_start = (state_r == ST_DIVS) && (den_r != '0) && (w_r != '0);

  jprt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (den_r),
    .done (div_done),
    .quot (div_quot)
  );

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    p_r <= a_r * b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_b_r     <= '0;
      sum_g_r     <= '0;
      sum_c_r     <= '0;
      phase_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mb_r    <= mag_b;
            mg_r    <= {mag_g, 1'b0};
            xsign_r <= in_b_term[DW-1] ^ in_g_term[DW-1];
            last_r  <= in_last_state;
            a_r     <= MW'(mag_b);
            b_r     <= MW'(mag_b);
            state_r <= ST_MB;
          end
        end
        ST_MB: begin
          a_r     <= MW'(mg_r);
          b_r     <= MW'(mg_r);
          state_r <= ST_AB;
        end
        ST_AB: begin
          sum_b_r <= jprt_pkg::sat_add(sum_b_r, jprt_pkg::clamp_prod(p_r), 1'b0);
          a_r     <= MW'(mb_r);
          b_r     <= MW'(mg_r);
          state_r <= ST_AG;
        end
        ST_AG: begin
          sum_g_r <= jprt_pkg::sat_add(sum_g_r, jprt_pkg::clamp_prod(p_r), 1'b0);
          state_r <= ST_AC;
        end
        ST_AC: begin
          sum_c_r <= jprt_pkg::sat_add(sum_c_r, jprt_pkg::clamp_prod(p_r), xsign_r);
          state_r <= last_r ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          xneg_r  <= xon[SW-1];
          xm_r    <= xon[SW-1] ? -xon : xon;
          yneg_r  <= sum_c_r[SW-1];
          yzero_r <= (sum_c_r == '0);
          ym_r    <= {ac[SW-2:0], 1'b0};
          sum_b_r <= '0;
          sum_g_r <= '0;
          sum_c_r <= '0;
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          // common right shift until both magnitudes fit below 2^29
          if ((|xm_r[SW-1:jprt_pkg::NORM_BIT]) || (|ym_r[SW-1:jprt_pkg::NORM_BIT])) begin
            xm_r <= xm_r >> 1;
            ym_r <= ym_r >> 1;
          end else begin
            u_r     <= xm_r[MW-1:0];
            w_r     <= ym_r[MW-1:0];
            phase_r <= 1'b0;
            state_r <= ST_SQX;
          end
        end
        ST_SQX: begin
          a_r     <= u_r;
          b_r     <= u_r;
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          a_r     <= w_r;
          b_r     <= w_r;
          state_r <= ST_SQSUM;
        end
        ST_SQSUM: begin
          v_r     <= p_r[SW-1:0];
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          v_r     <= v_r + p_r[SW-1:0];
          res_r   <= '0;
          bit_r   <= {2'b01, {(SW-2){1'b0}}};
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (bit_r == '0) begin
            state_r <= ST_HALF;
          end else begin
            if (v_r >= trial) begin
              v_r   <= v_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        ST_HALF: begin
          if (!phase_r) begin
            // half-angle vector, avoiding cancellation when x is negative
            if (!xneg_r) begin
              u_r    <= u_r + res_r[MW-1:0];
              qneg_r <= yneg_r;
            end else begin
              u_r    <= w_r;
              w_r    <= yzero_r ? '0 : (res_r[MW-1:0] + u_r);
              qneg_r <= !yzero_r && yneg_r;
            end
            phase_r <= 1'b1;
            state_r <= ST_SQX;
          end else begin
            den_r   <= jprt_pkg::DEN_W'(u_r) + res_r[jprt_pkg::DEN_W-1:0];
            state_r <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (div_start) begin
            state_r <= ST_DIVW;
          end else begin
            result_r <= '0;
            state_r  <= ST_DONE;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            result_r <= qneg_r ? div_quot : -div_quot;
            state_r  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= result_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_neg_tan_theta = out_data_r;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word appeared outside the done state");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_data_r) <= $signed(32'sh4000_0000)
                     && $signed(out_data_r) >= $signed(-32'sh4000_0000)))
    else $error("tangent magnitude above one");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider finished while not awaited");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE) |=> (sum_b_r == '0 && sum_g_r == '0 && sum_c_r == '0))
    else $error("sums not cleared after closing");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Jacobi pair rotation tangent block.
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  class tangent_scoreboard;
    logic signed [63:0] acc_bb, acc_gg, acc_bg;
    logic signed [31:0] tan_q[$];
    int unsigned errors;

    function new();
      acc_bb = 0; acc_gg = 0; acc_bg = 0; errors = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function logic [63:0] clamp_mag(logic [127:0] p);
      return (p > {64'd0, ACC_MAX}) ? ACC_MAX : p[63:0];
    endfunction

    function logic signed [63:0] add_sat(logic signed [63:0] acc, logic [63:0] mag,
                                         logic neg);
      logic signed [66:0] a, m, s;
      a = acc;
      m = {3'b000, mag};
      s = neg ? a - m : a + m;
      if (s >= ACC_MAX) return ACC_MAX;
      if (s <= -ACC_MAX) return -ACC_MAX;
      return s[63:0];
    endfunction

    function logic [31:0] closing_tangent();
      logic signed [65:0] xon;
      logic xneg, yneg, qneg;
      logic [65:0] ax, ac, ay, m;
      logic [63:0] x, y, r, p, aq, r1, den, mag;
      int s;
      xon = acc_bb - acc_gg;
      xneg = xon < 0;
      ax = xneg ? -xon : xon;
      yneg = acc_bg < 0;
      ac = yneg ? -{{2{acc_bg[63]}}, acc_bg} : {2'b00, acc_bg};
      ay = ac << 1;
      m = (ax > ay) ? ax : ay;
      s = 0;
      while ((m >> s) >= (66'd1 << 29)) s++;
      x = ax >> s;
      y = ay >> s;
      r = int_sqrt(x * x + y * y);
      if (!xneg) begin
        p = x + r; aq = y; qneg = yneg;
      end else begin
        p = y;
        aq = (ay == 0) ? 64'd0 : r + x;
        qneg = (ay != 0) && yneg;
      end
      r1 = int_sqrt(p * p + aq * aq);
      den = p + r1;
      if (den == 0 || aq == 0) return 32'd0;
      mag = ((aq << 30) + (den >> 1)) / den;
      return qneg ? mag[31:0] : (32'd0 - mag[31:0]);
    endfunction

    function void note_word(logic [31:0] b, logic [31:0] g, logic last);
      logic [33:0] mb, mg;
      logic nb, ng;
      nb = b[31]; ng = g[31];
      mb = nb ? (34'h1_0000_0000 - {2'b00, b}) : {2'b00, b};
      mg = ng ? (34'h1_0000_0000 - {2'b00, g}) : {2'b00, g};
      mg = mg << 1;
      acc_bb = add_sat(acc_bb, clamp_mag(mb * mb), 1'b0);
      acc_gg = add_sat(acc_gg, clamp_mag(mg * mg), 1'b0);
      acc_bg = add_sat(acc_bg, clamp_mag(mb * mg), nb != ng);
      if (last) begin
        tan_q.push_back(closing_tangent());
        acc_bb = 0; acc_gg = 0; acc_bg = 0;
      end
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (tan_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = tan_q.pop_front();
      if (got !== want) begin
        $display("%0t: neg_tan_theta mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_state, out_valid, out_stall;
  logic signed [31:0] in_b_term, in_g_term;
  logic signed [jprt_pkg::RES_W-1:0] out_neg_tan_theta;

  tangent_scoreboard sb;
  int idle_cycles;
  int burst_left;

  jacobi_pair_rotation_tangent_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_b_term(in_b_term), .in_g_term(in_g_term), .in_last_state(in_last_state),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_neg_tan_theta(out_neg_tan_theta)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern: runs of free, random and heavy stalling
  int stall_mode, stall_run;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run <= $urandom_range(5, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_neg_tan_theta);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(logic [31:0] b, logic [31:0] g, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_b_term <= b;
    in_g_term <= g;
    in_last_state <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(b, g, last);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4, 5: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      6: return $urandom_range(0, 32'h0000_0FFF) - 32'h0000_0800;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, len;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_b_term = 0;
    in_g_term = 0;
    in_last_state = 1'b0;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_run = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all sums zero
    send_word(32'd0, 32'd0, 1'b1);
    // most negative inputs, saturating gradient product
    send_word(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    // zero cross term with negative t_on: zero denominator
    send_word(32'd0, 32'h0100_0000, 1'b1);
    // zero cross term with positive t_on
    send_word(32'h0100_0000, 32'd0, 1'b1);
    // tiny cross term against large negative t_on, both signs
    send_word(32'h0000_0001, 32'h7000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 32'h7000_0000, 1'b1);
    // sum saturation over several words
    repeat (4) send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    repeat (3) send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    // mixed-sign small pair
    send_word(32'h0100_0000, 32'hFF00_0000, 1'b0);
    send_word(32'hFF80_0000, 32'h0080_0000, 1'b1);

    n = 0;
    while (n < 600) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_word(pick_value(), pick_value(),
                  (i == len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
        n++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.tan_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.tan_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
